// ===== design/nrfe_pkg.sv =====
// Package for the RMC field extractor: character codes, fix codes and header lookup.
`timescale 1ns / 1ps

package nrfe_pkg;

	localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$'
	localparam logic [7:0] CH_COMMA  = 8'h2C;  // ','
	localparam logic [7:0] CH_FIX_A  = 8'h41;  // 'A'
	localparam logic [7:0] CH_FIX_V  = 8'h56;  // 'V'

	localparam int unsigned HDR_LEN = 5;
	localparam int unsigned CC_MAX  = 15;

	typedef logic [2:0] hdr_pos_t;
	typedef logic [3:0] comma_cnt_t;
	typedef logic [1:0] fix_t;

	localparam fix_t FIX_UNKNOWN = 2'd0;
	localparam fix_t FIX_VOID    = 2'd1;
	localparam fix_t FIX_ACTIVE  = 2'd2;

	// Sentence field selected by the comma count
	localparam comma_cnt_t FLD_FIX = 4'd2;
	localparam comma_cnt_t FLD_LAT = 4'd3;
	localparam comma_cnt_t FLD_NS  = 4'd4;
	localparam comma_cnt_t FLD_LON = 4'd5;
	localparam comma_cnt_t FLD_EW  = 4'd6;

	// Expected header letter at each match position ("GPRMC")
	function automatic logic [7:0] hdr_letter(input hdr_pos_t pos);
		logic [7:0] letter;
		unique case (pos)
			3'd0:    letter = 8'h47;  // 'G'
			3'd1:    letter = 8'h50;  // 'P'
			3'd2:    letter = 8'h52;  // 'R'
			3'd3:    letter = 8'h4D;  // 'M'
			3'd4:    letter = 8'h43;  // 'C'
			default: letter = 8'h00;
		endcase
		return letter;
	endfunction

endpackage

// ===== design/nmea_rmc_field_extractor_unit.sv =====
// Top level of the NMEA RMC field extractor: byte register, sentence state, result register.
`timescale 1ns / 1ps

// Takes one received sentence byte per transfer and returns one result per byte, reflecting the
// sentence state after that byte: header match, fix status, hemisphere bytes, field-done flags
// and, for latitude/longitude bytes, the captured character with its index. A '$' restarts the
// sentence. Throughput is one byte per clock while out_stall is low; each byte passes the input
// register, then the result register. The input register acts as a skid stage, so one more byte
// is taken while a result waits on out_stall. Coordinate characters past MAX_FIELD_CHARS per field
// are dropped and set the sticky overflow flag until the next '$'.
module nmea_rmc_field_extractor_unit
	import nrfe_pkg::*;
#(
	parameter int unsigned MAX_FIELD_CHARS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       header_ok,
	output logic [1:0] fix_status,
	output logic       lat_done,
	output logic [7:0] ns_char,
	output logic       lon_done,
	output logic [7:0] ew_char,
	output logic       char_valid,
	output logic       char_field,
	output logic [3:0] char_index,
	output logic [7:0] char_value,
	output logic       overflow
);

	localparam int unsigned PW = $clog2(MAX_FIELD_CHARS + 1);

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          advance;

	hdr_pos_t      header_pos_q;
	comma_cnt_t    comma_count_q;
	fix_t          fix_state_q;
	logic          lat_finished_q;
	logic [7:0]    ns_hold_q;
	logic          lon_finished_q;
	logic [7:0]    ew_hold_q;
	logic [PW-1:0] char_pos_q;
	logic          overflow_hold_q;

	hdr_pos_t      hp_d;
	comma_cnt_t    cc_d;
	fix_t          fix_d;
	logic          lat_d;
	logic [7:0]    ns_d;
	logic          lon_d;
	logic [7:0]    ew_d;
	logic [PW-1:0] pos_d;
	logic          ovf_d;
	logic          cv_d;
	logic          cfield_d;
	logic [PW+3:0] cidx_ext;
	logic          is_comma;
	logic          restart;
	logic          can_take;

	// Result register frees up when empty or being taken downstream
	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && out_valid && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	always_comb begin
		is_comma = (byte_s1 == CH_COMMA);
		restart  = (byte_s1 == CH_DOLLAR);

		hp_d     = restart ? '0 : header_pos_q;
		cc_d     = restart ? '0 : comma_count_q;
		fix_d    = restart ? FIX_UNKNOWN : fix_state_q;
		lat_d    = restart ? 1'b0 : lat_finished_q;
		ns_d     = restart ? 8'h00 : ns_hold_q;
		lon_d    = restart ? 1'b0 : lon_finished_q;
		ew_d     = restart ? 8'h00 : ew_hold_q;
		pos_d    = restart ? '0 : char_pos_q;
		ovf_d    = restart ? 1'b0 : overflow_hold_q;
		cv_d     = 1'b0;
		cfield_d = 1'b0;
		cidx_ext = '0;

		if (hp_d < hdr_pos_t'(HDR_LEN) && hdr_letter(hp_d) == byte_s1) begin
			hp_d = hp_d + hdr_pos_t'(1);
		end
		if (is_comma && cc_d < comma_cnt_t'(CC_MAX)) begin
			cc_d = cc_d + comma_cnt_t'(1);
		end

		can_take = (pos_d < PW'(MAX_FIELD_CHARS));

		case (cc_d)
			FLD_FIX: begin
				if (byte_s1 == CH_FIX_A) begin
					fix_d = FIX_ACTIVE;
				end else if (byte_s1 == CH_FIX_V) begin
					fix_d = FIX_VOID;
				end
			end
			FLD_LAT, FLD_LON: begin
				if (!is_comma) begin
					if (can_take) begin
						cv_d     = 1'b1;
						cfield_d = (cc_d == FLD_LON);
						cidx_ext = {4'b0000, pos_d};
						pos_d    = pos_d + PW'(1);
					end else begin
						ovf_d = 1'b1;
					end
				end
			end
			FLD_NS: begin
				lat_d = 1'b1;
				pos_d = '0;
				if (!is_comma) begin
					ns_d = byte_s1;
				end
			end
			FLD_EW: begin
				lon_d = 1'b1;
				if (!is_comma) begin
					ew_d = byte_s1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_pos_q    <= '0;
			comma_count_q   <= '0;
			fix_state_q     <= FIX_UNKNOWN;
			lat_finished_q  <= 1'b0;
			ns_hold_q       <= 8'h00;
			lon_finished_q  <= 1'b0;
			ew_hold_q       <= 8'h00;
			char_pos_q      <= '0;
			overflow_hold_q <= 1'b0;
			out_valid       <= 1'b0;
		end else begin
			if (advance) begin
				header_pos_q    <= hp_d;
				comma_count_q   <= cc_d;
				fix_state_q     <= fix_d;
				lat_finished_q  <= lat_d;
				ns_hold_q       <= ns_d;
				lon_finished_q  <= lon_d;
				ew_hold_q       <= ew_d;
				char_pos_q      <= pos_d;
				overflow_hold_q <= ovf_d;
			end
			if (!out_valid || !out_stall) begin
				out_valid <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			header_ok  <= (hp_d == hdr_pos_t'(HDR_LEN));
			fix_status <= fix_d;
			lat_done   <= lat_d;
			ns_char    <= ns_d;
			lon_done   <= lon_d;
			ew_char    <= ew_d;
			char_valid <= cv_d;
			char_field <= cfield_d;
			char_index <= cidx_ext[3:0];
			char_value <= cv_d ? byte_s1 : 8'h00;
			overflow   <= ovf_d;
		end
	end

endmodule
